// ===== sv/lpht_pkg.sv =====
// shared types, constants and a helper function for the linear probe hash table
`default_nettype none
package lpht_pkg;
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] key;
    logic [63:0]        put_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [10:0] occupancy;
    logic [63:0] content_digest;
  } out_beat_t;

  // request after hashing, passed from front to back
  typedef struct packed {
    logic [1:0]       opcode;
    logic [63:0]      key;
    logic [63:0]      put_value;
    logic [IDX_W-1:0] home;
    logic [63:0]      mix_key;
    logic [63:0]      mix_val;
  } req_t;

  // 32x32 partial products are summed over cycles in the hash unit
  function automatic logic [31:0] lo32(input logic [63:0] x);
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/lpht_mix.sv =====
// sequential splitmix64 finalizer using one 32x32 multiplier
`default_nettype none
module lpht_mix (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x_in,
  output logic             done,
  output logic [63:0]      y_out
);
  // steps: per multiply three partial products (ll, lh, hl) mod 2^64
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P0   = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;

  logic [3:0]  st_r, st_nxt;
  logic        rnd_r, rnd_nxt;
  logic [63:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] cst;

  assign cst  = rnd_r ? lpht_pkg::MIX_C2 : lpht_pkg::MIX_C1;
  assign prod = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    ma = lpht_pkg::lo32(a_r);
    mb = lpht_pkg::lo32(cst);
    case (st_r)
      S_P1: begin ma = a_r[63:32]; mb = cst[31:0]; end
      S_P2: begin ma = a_r[31:0]; mb = cst[63:32]; end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r; rnd_nxt = rnd_r; a_nxt = a_r; acc_nxt = acc_r; done = 1'b0;
    case (st_r)
      S_IDLE: if (start) begin
        a_nxt = x_in ^ (x_in >> 30); rnd_nxt = 1'b0; st_nxt = S_P0;
      end
      S_P0: begin acc_nxt = prod; st_nxt = S_P1; end
      S_P1: begin acc_nxt = acc_r + {prod[31:0], 32'd0}; st_nxt = S_P2; end
      S_P2: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
        if (!rnd_r) begin
          a_nxt = acc_nxt ^ (acc_nxt >> 27); rnd_nxt = 1'b1; st_nxt = S_P0;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        done = 1'b1;
        // a new pass may start in the cycle that delivers the result
        if (start) begin
          a_nxt = x_in ^ (x_in >> 30); rnd_nxt = 1'b0; st_nxt = S_P0;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign y_out = acc_r ^ (acc_r >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    rnd_r <= rnd_nxt; a_r <= a_nxt; acc_r <= acc_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/lpht_front.sv =====
// front: accepts requests, hashes key and value, queues them for the back
`default_nettype none
module lpht_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lpht_pkg::in_beat_t in_beat,
  output logic                    q_valid,
  output lpht_pkg::req_t          q_req,
  input  wire logic               q_pop
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_KEY  = 2'd1;
  localparam logic [1:0] F_VAL  = 2'd2;

  logic [1:0]         st_r;
  lpht_pkg::in_beat_t cur_r;
  logic [63:0]        hk_r;
  logic               m_start, m_done;
  logic [63:0]        m_x, m_y;
  // two-entry queue
  lpht_pkg::req_t     q_mem_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push;

  assign busy = (st_r != F_IDLE) || (cnt_r == 2'd2);
  assign m_start = (st_r == F_IDLE && start && !busy) || (st_r == F_KEY && m_done);
  assign m_x = (st_r == F_IDLE) ? in_beat.key : cur_r.put_value;
  assign push = (st_r == F_VAL) && m_done;

  lpht_mix u_mix (
    .clk(clk), .rst_n(rst_n), .start(m_start), .x_in(m_x), .done(m_done), .y_out(m_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE; wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      case (st_r)
        F_IDLE: if (start && !busy) st_r <= F_KEY;
        F_KEY: if (m_done) st_r <= F_VAL;
        F_VAL: if (m_done) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (st_r == F_IDLE && start && !busy) cur_r <= in_beat;
    if (st_r == F_KEY && m_done) hk_r <= m_y;
    if (push) begin
      q_mem_r[wp_r].opcode    <= cur_r.opcode;
      q_mem_r[wp_r].key       <= cur_r.key;
      q_mem_r[wp_r].put_value <= cur_r.put_value;
      q_mem_r[wp_r].home      <= hk_r[lpht_pkg::IDX_W-1:0];
      q_mem_r[wp_r].mix_key   <= hk_r;
      q_mem_r[wp_r].mix_val   <= m_y;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_req = q_mem_r[rp_r];
endmodule
`default_nettype wire

// ===== sv/lpht_back.sv =====
// back: probes the slot memories, updates, and runs backward-shift deletion
`default_nettype none
module lpht_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_digest_en,
  input  wire logic           q_valid,
  input  wire lpht_pkg::req_t q_req,
  output logic                q_pop,
  output logic                out_valid,
  output lpht_pkg::out_beat_t out_beat
);
  localparam int unsigned IW = lpht_pkg::IDX_W;
  localparam int unsigned N = lpht_pkg::TABLE_SLOTS;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_RD    = 4'd1;
  localparam logic [3:0] B_CHK   = 4'd2;
  localparam logic [3:0] B_OVH   = 4'd3;  // hash old value on update/remove
  localparam logic [3:0] B_DONE  = 4'd4;
  localparam logic [3:0] B_SRD   = 4'd5;  // shift: read next slot
  localparam logic [3:0] B_SCHK  = 4'd6;
  localparam logic [3:0] B_SMOV  = 4'd7;  // shift: wait for home of next key
  localparam logic [3:0] B_SFREE = 4'd8;  // shift: free the slot just moved
  localparam logic [3:0] B_CLR   = 4'd9;  // clear occupancy after reset

  logic [63:0] key_mem [N];
  logic [63:0] val_mem [N];
  logic        used_mem [N];

  logic [3:0]  st_r;
  lpht_pkg::req_t req_r;
  logic [IW-1:0] pos_r, hole_r;
  logic [IW:0]   n_r;
  logic [63:0]   rk_r, rv_r;
  logic          ru_r;
  logic [lpht_pkg::CNT_W-1:0] cnt_r;
  logic [63:0]   dig_r;
  logic [2:0]    stat_r;
  logic [63:0]   got_r;
  logic          m_start, m_done;
  logic [63:0]   m_x, m_y;

  lpht_mix u_mix (
    .clk(clk), .rst_n(rst_n), .start(m_start), .x_in(m_x), .done(m_done), .y_out(m_y)
  );

  logic hit, stays, at_end, wr_op;
  logic [IW-1:0] h;
  assign hit = ru_r && (rk_r == req_r.key);
  assign at_end = (n_r == (IW+1)'(N));
  assign wr_op = (req_r.opcode == lpht_pkg::OP_PUT) ||
                 (req_r.opcode == lpht_pkg::OP_REMOVE);
  assign h = m_y[IW-1:0];
  always_comb begin
    if (hole_r <= pos_r) stays = (h > hole_r) && (h <= pos_r);
    else stays = (h > hole_r) || (h <= pos_r);
  end

  assign q_pop = (st_r == B_IDLE) && q_valid;
  assign m_start = (st_r == B_CHK && !at_end && hit && wr_op) ||
                   (st_r == B_SCHK && ru_r && !at_end);
  assign m_x = (st_r == B_CHK) ? rv_r : rk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR; pos_r <= '0; cnt_r <= '0; dig_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= (st_r == B_DONE);
      case (st_r)
        B_CLR: begin
          used_mem[pos_r] <= 1'b0; pos_r <= pos_r + 1'b1;
          if (pos_r == IW'(N - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (q_valid) begin
          req_r <= q_req; pos_r <= q_req.home; n_r <= '0; got_r <= '0; st_r <= B_RD;
        end
        B_RD: st_r <= B_CHK;
        B_CHK: begin
          if (at_end) begin
            if (req_r.opcode == lpht_pkg::OP_PUT) stat_r <= lpht_pkg::ST_FULL;
            else stat_r <= lpht_pkg::ST_NOT_FOUND;
            st_r <= B_DONE;
          end else if (!ru_r) begin
            if (req_r.opcode == lpht_pkg::OP_PUT) begin
              key_mem[pos_r] <= req_r.key; val_mem[pos_r] <= req_r.put_value;
              used_mem[pos_r] <= 1'b1; cnt_r <= cnt_r + 1'b1;
              dig_r <= dig_r ^ req_r.mix_key ^ req_r.mix_val;
              stat_r <= lpht_pkg::ST_INSERTED;
            end else begin
              stat_r <= lpht_pkg::ST_NOT_FOUND;
            end
            st_r <= B_DONE;
          end else if (hit) begin
            if (req_r.opcode == lpht_pkg::OP_PUT) begin
              val_mem[pos_r] <= req_r.put_value;
              dig_r <= dig_r ^ req_r.mix_val;
              stat_r <= lpht_pkg::ST_UPDATED; st_r <= B_OVH;
            end else if (req_r.opcode == lpht_pkg::OP_REMOVE) begin
              used_mem[pos_r] <= 1'b0; cnt_r <= cnt_r - 1'b1;
              dig_r <= dig_r ^ req_r.mix_key;
              hole_r <= pos_r; stat_r <= lpht_pkg::ST_REMOVED; st_r <= B_OVH;
            end else begin
              got_r <= rv_r; stat_r <= lpht_pkg::ST_FOUND; st_r <= B_DONE;
            end
          end else begin
            pos_r <= pos_r + 1'b1; n_r <= n_r + 1'b1; st_r <= B_RD;
          end
        end
        B_OVH: if (m_done) begin
          dig_r <= dig_r ^ m_y;
          if (stat_r == lpht_pkg::ST_REMOVED) begin
            pos_r <= hole_r + 1'b1; n_r <= '0; st_r <= B_SRD;
          end else begin
            st_r <= B_DONE;
          end
        end
        B_SRD: st_r <= B_SCHK;
        B_SCHK: begin
          if (!ru_r || at_end) st_r <= B_DONE;
          else st_r <= B_SMOV;
        end
        B_SMOV: if (m_done) begin
          if (!stays) begin
            key_mem[hole_r] <= rk_r; val_mem[hole_r] <= rv_r;
            used_mem[hole_r] <= 1'b1; hole_r <= pos_r; st_r <= B_SFREE;
          end else begin
            pos_r <= pos_r + 1'b1; n_r <= n_r + 1'b1; st_r <= B_SRD;
          end
        end
        B_SFREE: begin
          used_mem[pos_r] <= 1'b0;
          pos_r <= pos_r + 1'b1; n_r <= n_r + 1'b1; st_r <= B_SRD;
        end
        B_DONE: begin
          st_r <= B_IDLE;
          out_beat.status <= stat_r;
          out_beat.found_value <= got_r;
          out_beat.occupancy <= 11'(cnt_r);
          out_beat.content_digest <= cfg_digest_en ? (dig_r ^ 64'(cnt_r)) : 64'd0;
        end
        default: st_r <= B_IDLE;
      endcase
    end
    rk_r <= key_mem[pos_r];
    rv_r <= val_mem[pos_r];
    ru_r <= used_mem[pos_r];
  end
endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_table_core.sv =====
// top level of the linear probe hash table
`default_nettype none
// usage:
// - raise start with in_beat while busy is low; the beat is taken at that edge
// - each request gives one result beat, out_valid high for exactly one cycle
// - the receiver cannot stall; results come in request order
// - front: two splitmix64 passes on one 32x32 multiplier, key then value;
//   busy stays high while both passes run after a beat is taken
// - a two-entry queue lets the front hash the next request while back probes;
//   busy is also high while that queue is full
// - back: each probed slot passes through B_RD (registered memory read) and B_CHK
// - update and remove also hash the old value; remove then runs the shift,
//   which reads and hashes the key of each slot examined and frees the slot of each key it moves
// - synchronous active-low reset clears count and digest; the back then
//   clears all 1024 occupancy entries before its first result
// - cfg_wr_en writes digest_enable from cfg_wr_data; reset value is 0
module linear_probe_hash_table_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lpht_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  output lpht_pkg::out_beat_t      out_beat,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data
);
  logic           digest_en_r;
  logic           q_valid, q_pop;
  lpht_pkg::req_t q_req;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) digest_en_r <= 1'b0;
    else if (cfg_wr_en) digest_en_r <= cfg_wr_data;
  end

  lpht_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  lpht_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_digest_en(digest_en_r), .q_valid(q_valid),
    .q_req(q_req), .q_pop(q_pop), .out_valid(out_valid), .out_beat(out_beat)
  );
endmodule
`default_nettype wire

// ===== test/tb_linear_probe_hash_table_core.sv =====
// testbench for the linear probe hash table: directed and random requests
`timescale 1ns / 100ps
module tb_linear_probe_hash_table_core;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  lpht_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  lpht_pkg::out_beat_t out_beat;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;

  linear_probe_hash_table_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the table
  logic [63:0] tbl_key [lpht_pkg::TABLE_SLOTS];
  logic [63:0] tbl_val [lpht_pkg::TABLE_SLOTS];
  logic        tbl_used [lpht_pkg::TABLE_SLOTS];
  int unsigned tbl_count;
  logic [63:0] tbl_digest;
  logic        digest_on;

  lpht_pkg::out_beat_t expected_q[$];
  int          mismatch_count = 0;
  logic [63:0] key_pool[$];

  function automatic logic [63:0] splitmix(input logic [63:0] x);
    x = (x ^ (x >> 30)) * lpht_pkg::MIX_C1;
    x = (x ^ (x >> 27)) * lpht_pkg::MIX_C2;
    return x ^ (x >> 31);
  endfunction

  function automatic int unsigned home_of(input logic [63:0] k);
    return 32'(splitmix(k) % 64'(lpht_pkg::TABLE_SLOTS));
  endfunction

  // backward-shift deletion starting at the freed slot
  function automatic void shift_back(input int unsigned hole);
    int unsigned j, h;
    bit keep;
    j = hole;
    tbl_used[hole] = 1'b0;
    for (int n = 0; n < lpht_pkg::TABLE_SLOTS; n++) begin
      j = (j + 1) % lpht_pkg::TABLE_SLOTS;
      if (!tbl_used[j]) break;
      h = home_of(tbl_key[j]);
      if (hole <= j) keep = (h > hole) && (h <= j);
      else keep = (h > hole) || (h <= j);
      if (!keep) begin
        tbl_key[hole] = tbl_key[j];
        tbl_val[hole] = tbl_val[j];
        tbl_used[hole] = 1'b1;
        tbl_used[j] = 1'b0;
        hole = j;
      end
    end
  endfunction

  function automatic lpht_pkg::out_beat_t predict_request(input lpht_pkg::in_beat_t b);
    lpht_pkg::out_beat_t r;
    int unsigned i, pos;
    bit hit, has_free;
    logic [63:0] k;
    k = b.key;
    hit = 0; has_free = 0; pos = 0;
    i = home_of(k);
    for (int n = 0; n < lpht_pkg::TABLE_SLOTS; n++) begin
      if (!tbl_used[i]) begin pos = i; has_free = 1; break; end
      if (tbl_key[i] == k) begin pos = i; hit = 1; break; end
      i = (i + 1) % lpht_pkg::TABLE_SLOTS;
    end
    r = '0;
    if (b.opcode == lpht_pkg::OP_PUT) begin
      if (hit) begin
        tbl_digest ^= splitmix(tbl_val[pos]) ^ splitmix(b.put_value);
        tbl_val[pos] = b.put_value;
        r.status = lpht_pkg::ST_UPDATED;
      end else if (has_free) begin
        tbl_key[pos] = k;
        tbl_val[pos] = b.put_value;
        tbl_used[pos] = 1'b1;
        tbl_count++;
        tbl_digest ^= splitmix(k) ^ splitmix(b.put_value);
        r.status = lpht_pkg::ST_INSERTED;
      end else r.status = lpht_pkg::ST_FULL;
    end else if (b.opcode == lpht_pkg::OP_REMOVE) begin
      if (hit) begin
        tbl_digest ^= splitmix(k) ^ splitmix(tbl_val[pos]);
        tbl_count--;
        shift_back(pos);
        r.status = lpht_pkg::ST_REMOVED;
      end else r.status = lpht_pkg::ST_NOT_FOUND;
    end else begin
      // get, and the unused opcode behaves as a get
      if (hit) begin
        r.found_value = tbl_val[pos];
        r.status = lpht_pkg::ST_FOUND;
      end else r.status = lpht_pkg::ST_NOT_FOUND;
    end
    r.occupancy = tbl_count[10:0];
    r.content_digest = digest_on ? (tbl_digest ^ 64'(tbl_count)) : 64'd0;
    return r;
  endfunction

  // one request beat, with a random gap first unless no_gap is set; start is left high afterwards
  task automatic send_request(input logic [1:0] op, input logic [63:0] k,
                              input logic [63:0] v, input bit no_gap = 0);
    lpht_pkg::in_beat_t b;
    int gap;
    b.opcode = op; b.key = k; b.put_value = v;
    gap = no_gap ? 0 : int'($urandom_range(0, 5));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_request(b));
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_digest_enable(input logic en);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    digest_on = en;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // result checker
  always @(posedge clk) begin
    lpht_pkg::out_beat_t exp_b;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %p", out_beat);
      end else begin
        exp_b = expected_q.pop_front();
        if (out_beat !== exp_b) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, actual %p", exp_b, out_beat);
        end
      end
    end
  end

  task automatic test_directed;
    send_request(lpht_pkg::OP_GET, 64'h0, 64'h0);
    send_request(lpht_pkg::OP_PUT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lpht_pkg::OP_PUT, 64'h8000_0000_0000_0000, 64'h0);
    send_request(lpht_pkg::OP_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1);
    send_request(lpht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_request(lpht_pkg::OP_PUT, 64'h0, 64'h1234);           // update
    send_request(lpht_pkg::OP_GET, 64'h0, 64'hFFFF);
    // unused opcode as get
    send_request(lpht_pkg::OP_SPARE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(lpht_pkg::OP_REMOVE, 64'h8000_0000_0000_0000, 64'h0);
    send_request(lpht_pkg::OP_REMOVE, 64'h8000_0000_0000_0000, 64'h0); // already gone
    send_request(lpht_pkg::OP_GET, 64'h8000_0000_0000_0000, 64'h0);
    send_request(lpht_pkg::OP_SPARE, 64'h5555, 64'h0);
  endtask

  // fill part of the table, miss on a new key, update, then remove the keys it put
  task automatic test_fill_empty(input int n_keys);
    logic [63:0] k;
    key_pool.delete();
    for (int n = 0; n < n_keys; n++) begin
      k = rand64();
      key_pool.push_back(k);
      send_request(lpht_pkg::OP_PUT, k, rand64(), $urandom_range(0, 3) != 0);
    end
    send_request(lpht_pkg::OP_GET, 64'hDEAD_BEEF, 64'h0);
    send_request(lpht_pkg::OP_REMOVE, 64'hDEAD_BEEF, 64'h0);
    send_request(lpht_pkg::OP_PUT, key_pool[0], 64'h77);
    send_request(lpht_pkg::OP_GET, key_pool[0], 64'h0);
    foreach (key_pool[i]) send_request(lpht_pkg::OP_REMOVE, key_pool[i], 64'h0, 1'b1);
    key_pool.delete();
  endtask

  // random traffic mostly on a small key pool so hits and chains happen
  task automatic test_random(input int n_items);
    logic [63:0] k;
    logic [1:0] op;
    int sel;
    for (int n = 0; n < n_items; n++) begin
      if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
        k = rand64();
        if (key_pool.size() < 300) key_pool.push_back(k);
      end else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      sel = int'($urandom_range(0, 9));
      if (sel inside {[0:3]}) op = lpht_pkg::OP_PUT;
      else if (sel inside {[4:6]}) op = lpht_pkg::OP_GET;
      else if (sel inside {[7:8]}) op = lpht_pkg::OP_REMOVE;
      else op = lpht_pkg::OP_SPARE;
      send_request(op, k, rand64(), $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    tbl_count = 0;
    tbl_digest = '0;
    digest_on = 1'b0;
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (5) @(negedge clk);

    test_directed();
    write_digest_enable(1'b1);
    test_directed();
    test_random(120);
    write_digest_enable(1'b0);
    test_random(100);
    write_digest_enable(1'b1);
    test_fill_empty(80);
    test_random(100);
    drain();
    if (mismatch_count == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/lpht_pkg.sv
sv/lpht_mix.sv
sv/lpht_front.sv
sv/lpht_back.sv
sv/linear_probe_hash_table_core.sv
test/tb_linear_probe_hash_table_core.sv
